@@ rtl/core/srb_pkg.sv @@
`timescale 1ns / 1ps

package srb_pkg;

    // trip counts are fixed-width registers, independent of the run counter width
    localparam int TRIP_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;

    // start rate loaded at reset, truncated to the rate width where it is used
    localparam logic [63:0] START_RESET = 64'd1000000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RATE_FLOOR   = 3'd0,
        CFG_RATE_CEILING = 3'd1,
        CFG_RATE_START   = 3'd2,
        CFG_FAIL_TRIP    = 3'd3,
        CFG_OK_TRIP      = 3'd4
    } cfg_idx_t;

    // zero trip count acts as one
    function automatic logic [TRIP_BITS-1:0] trip_of(input logic [TRIP_BITS-1:0] t);
        trip_of = (t == '0) ? TRIP_BITS'(1) : t;
    endfunction

endpackage

@@ rtl/core/srb_req_if.sv @@
`timescale 1ns / 1ps

interface srb_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic crc_good;

    modport source (output valid, output req_type, output crc_good, input ready);
    modport sink   (input valid, input req_type, input crc_good, output ready);
endinterface

@@ rtl/core/srb_rate_if.sv @@
`timescale 1ns / 1ps

interface srb_rate_if #(
    parameter int RATE_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [RATE_BITS-1:0] rate_now;

    modport source (output valid, output rate_now, input ready);
    modport sink   (input valid, input rate_now, output ready);
endinterface

@@ rtl/core/spi_clock_rate_backoff.sv @@
`timescale 1ns / 1ps

// spi clock rate backoff
//
// req carries one item per finished spi transfer (req_type = 0, crc_good
// gives the crc outcome) or a restart item (req_type = 1, crc_good ignored).
// rsp returns one item per request: the clock rate in hertz after that item.
// cfg_we / cfg_index / cfg_wdata write the floor, ceiling, start rate and the
// two trip counts; writes take effect for the next item, no read-back.
//
// the state update is a single compare, shift and clamp between the request
// handshake and the rate/run registers, and the result is shown from the
// rate register the next cycle.
// throughput is one item per cycle; req.ready stays high while the result
// register is empty or being taken, so only a stalled rsp holds off req.
//
// reset loads floor 0, ceiling all ones, start 1000000, trip counts 1, the
// rate as the clamped start rate and both runs cleared; rsp is empty.
module spi_clock_rate_backoff #(
    parameter int RATE_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    srb_req_if.sink                             req,
    srb_rate_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [srb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [((RATE_BITS > srb_pkg::TRIP_BITS) ? RATE_BITS
                   : srb_pkg::TRIP_BITS)-1:0]   cfg_wdata
);
    import srb_pkg::*;

    localparam int CFG_BITS = (RATE_BITS > TRIP_BITS) ? RATE_BITS : TRIP_BITS;
    localparam logic [RATE_BITS-1:0] RATE_START_RST = RATE_BITS'(START_RESET);

    // configuration
    logic [RATE_BITS-1:0] rate_floor, rate_ceiling, rate_start;
    logic [TRIP_BITS-1:0] fail_trip_count, ok_trip_count;

    // adaptation state
    logic [RATE_BITS-1:0] rate_reg, rate_next;
    logic [RUN_BITS-1:0]  good_run_reg, good_run_next;
    logic [RUN_BITS-1:0]  bad_run_reg, bad_run_next;
    logic                 out_valid_reg, out_valid_next;

    logic take;

    srb_cfg_regs #(
        .RATE_BITS (RATE_BITS),
        .CFG_BITS  (CFG_BITS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .rate_floor      (rate_floor),
        .rate_ceiling    (rate_ceiling),
        .rate_start      (rate_start),
        .fail_trip_count (fail_trip_count),
        .ok_trip_count   (ok_trip_count)
    );

    srb_rate_step #(
        .RATE_BITS (RATE_BITS),
        .RUN_BITS  (RUN_BITS)
    ) u_step (
        .restart         (req.req_type),
        .good            (req.crc_good),
        .rate            (rate_reg),
        .good_run        (good_run_reg),
        .bad_run         (bad_run_reg),
        .rate_floor      (rate_floor),
        .rate_ceiling    (rate_ceiling),
        .rate_start      (rate_start),
        .fail_trip_count (fail_trip_count),
        .ok_trip_count   (ok_trip_count),
        .rate_next       (rate_next),
        .good_run_next   (good_run_next),
        .bad_run_next    (bad_run_next)
    );

    // accept whenever the result slot is free or drains this cycle
    assign req.ready = !out_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state only moves on an accepted item; the rate register doubles as
    // the result payload, so it holds while rsp stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_START_RST;
            good_run_reg  <= '0;
            bad_run_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                rate_reg     <= rate_next;
                good_run_reg <= good_run_next;
                bad_run_reg  <= bad_run_next;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.rate_now = rate_reg;

    // every accepted item shows a result in the next cycle
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rsp.valid)
        else $error("accepted item produced no result");

    // a good and a bad run never coexist
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((good_run_reg != '0) && (bad_run_reg != '0)))
        else $error("good and bad runs both nonzero");

    // requests are only held off by a stalled result
    a_backpressure_only: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (rsp.valid && !rsp.ready))
        else $error("request stalled without a pending result");

    // a restart always leaves both runs cleared
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req.req_type) |=> ((good_run_reg == '0) && (bad_run_reg == '0)))
        else $error("restart left a run count");

endmodule

@@ rtl/core/srb_cfg_regs.sv @@
`timescale 1ns / 1ps

module srb_cfg_regs #(
    parameter int RATE_BITS = 32,
    parameter int CFG_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_wdata,
    output logic [RATE_BITS-1:0]                rate_floor,
    output logic [RATE_BITS-1:0]                rate_ceiling,
    output logic [RATE_BITS-1:0]                rate_start,
    output logic [srb_pkg::TRIP_BITS-1:0]       fail_trip_count,
    output logic [srb_pkg::TRIP_BITS-1:0]       ok_trip_count
);
    import srb_pkg::*;

    localparam logic [RATE_BITS-1:0] RATE_START_RST = RATE_BITS'(START_RESET);

    logic [RATE_BITS-1:0] floor_reg, ceiling_reg, start_reg;
    logic [TRIP_BITS-1:0] fail_trip_reg, ok_trip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg     <= '0;
            ceiling_reg   <= '1;
            start_reg     <= RATE_START_RST;
            fail_trip_reg <= TRIP_BITS'(1);
            ok_trip_reg   <= TRIP_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RATE_FLOOR:   floor_reg     <= cfg_wdata[RATE_BITS-1:0];
                CFG_RATE_CEILING: ceiling_reg   <= cfg_wdata[RATE_BITS-1:0];
                CFG_RATE_START:   start_reg     <= cfg_wdata[RATE_BITS-1:0];
                CFG_FAIL_TRIP:    fail_trip_reg <= cfg_wdata[TRIP_BITS-1:0];
                CFG_OK_TRIP:      ok_trip_reg   <= cfg_wdata[TRIP_BITS-1:0];
                default:          ; // unknown index ignored
            endcase
        end
    end

    assign rate_floor      = floor_reg;
    assign rate_ceiling    = ceiling_reg;
    assign rate_start      = start_reg;
    assign fail_trip_count = fail_trip_reg;
    assign ok_trip_count   = ok_trip_reg;

endmodule

@@ rtl/core/srb_rate_step.sv @@
`timescale 1ns / 1ps

module srb_rate_step #(
    parameter int RATE_BITS = 32,
    parameter int RUN_BITS  = 16
) (
    input  logic                          restart,
    input  logic                          good,
    input  logic [RATE_BITS-1:0]          rate,
    input  logic [RUN_BITS-1:0]           good_run,
    input  logic [RUN_BITS-1:0]           bad_run,
    input  logic [RATE_BITS-1:0]          rate_floor,
    input  logic [RATE_BITS-1:0]          rate_ceiling,
    input  logic [RATE_BITS-1:0]          rate_start,
    input  logic [srb_pkg::TRIP_BITS-1:0] fail_trip_count,
    input  logic [srb_pkg::TRIP_BITS-1:0] ok_trip_count,
    output logic [RATE_BITS-1:0]          rate_next,
    output logic [RUN_BITS-1:0]           good_run_next,
    output logic [RUN_BITS-1:0]           bad_run_next
);
    import srb_pkg::*;

    localparam int CMP_BITS = (RUN_BITS > TRIP_BITS) ? RUN_BITS : TRIP_BITS;

    logic [RUN_BITS-1:0]  good_inc, bad_inc;
    logic                 good_trip, bad_trip;
    logic [RATE_BITS-1:0] start_lo, start_clamped;
    logic [RATE_BITS-1:0] up, down;

    always_comb
    begin
        good_inc  = good_run + RUN_BITS'(1);
        bad_inc   = bad_run + RUN_BITS'(1);
        good_trip = CMP_BITS'(good_inc) >= CMP_BITS'(trip_of(ok_trip_count));
        bad_trip  = CMP_BITS'(bad_inc) >= CMP_BITS'(trip_of(fail_trip_count));

        // floor first, then ceiling
        start_lo      = (rate_start < rate_floor) ? rate_floor : rate_start;
        start_clamped = (start_lo > rate_ceiling) ? rate_ceiling : start_lo;

        // doubling saturates at the ceiling, also when the top bit falls off
        up = {rate[RATE_BITS-2:0], 1'b0};
        if (rate[RATE_BITS-1] || (up > rate_ceiling))
            up = rate_ceiling;

        down = {1'b0, rate[RATE_BITS-1:1]};
        if (down < rate_floor)
            down = rate_floor;

        if (restart)
        begin
            rate_next     = start_clamped;
            good_run_next = '0;
            bad_run_next  = '0;
        end
        else if (good)
        begin
            bad_run_next  = '0;
            good_run_next = good_trip ? '0 : good_inc;
            rate_next     = good_trip ? up : rate;
        end
        else
        begin
            good_run_next = '0;
            bad_run_next  = bad_trip ? '0 : bad_inc;
            rate_next     = bad_trip ? down : rate;
        end
    end

endmodule
